// File: rtl/ufpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufpc_pkg
// Shared types, character constants and helper functions for the
// form-urlencoded percent encoder / decoder.
// ----------------------------------------------------------------------------
package ufpc_pkg;

    // request payload on the input side
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // request payload on the output side
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    // one classified job: up to three output bytes
    localparam int JobBytes = 3;
    localparam int JobCntW  = $clog2(JobBytes + 1);

    typedef struct packed {
        logic [JobBytes-1:0][7:0] data;
        logic [JobCntW-1:0]       cnt;
        logic                     last;
    } t_job;

    // job queue geometry
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int QCw    = $clog2(QDepth + 1);

    typedef struct packed {
        logic           full;
        logic           empty;
        logic [QCw-1:0] count;
    } t_q_stat;

    // held-sequence state of the decoder
    typedef enum logic [1:0] {
        PendNone  = 2'd0,
        PendPct   = 2'd1,
        PendDigit = 2'd2
    } t_pend;

    // character codes
    localparam logic [7:0] ChPercent = 8'h25;
    localparam logic [7:0] ChPlus    = 8'h2B;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChTilde   = 8'h7E;
    localparam logic [7:0] ChDash    = 8'h2D;
    localparam logic [7:0] ChUnder   = 8'h5F;
    localparam logic [7:0] ChDot     = 8'h2E;
    localparam logic [3:0] NibMask   = 4'hF;

    // unreserved characters pass through the encoder
    function automatic logic keeps_as_is(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
               c == ChDash || c == ChUnder || c == ChDot || c == ChTilde;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    // uppercase hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [3:0] m;
        m = v & NibMask;
        return (m < 4'd10) ? (8'h30 + {4'd0, m}) : (8'h37 + {4'd0, m});
    endfunction

endpackage

// File: rtl/ufpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufpc_front
// Accepts input requests, holds the mode register and the pending escape
// state, and turns each byte into a job of zero to three output bytes.
// ----------------------------------------------------------------------------
module ufpc_front import ufpc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_in   i_in,
    output logic  o_in_stall,
    input  logic  i_cfg_valid,
    output logic  o_cfg_ready,
    input  logic  i_cfg_data,
    input  logic  i_q_full,
    output logic  o_push,
    output t_job  o_job
);

    logic                     r_mode;
    t_pend                    r_pend;
    t_pend                    n_pend;
    logic [7:0]               r_digit;
    logic [7:0]               n_digit;
    logic                     accept;
    logic [7:0]               b;
    logic                     last;
    logic                     p_hold;
    logic [7:0]               p_byte;
    logic [JobBytes-1:0][7:0] v_data;
    logic [JobCntW-1:0]       v_cnt;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign accept      = i_in_valid & ~i_q_full;
    assign b           = i_in.in_byte;
    assign last        = i_in.in_last;

    // plain decode of a byte with nothing held
    assign p_hold = (b == ChPercent) & ~last;
    assign p_byte = (b == ChPlus) ? ChSpace : b;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_pend <= PendNone;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
            r_pend <= PendNone;
        end else if (accept) begin
            r_pend <= n_pend;
        end
    end

    // held digit
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_digit <= n_digit;
        end
    end

    // classify and build the job
    always_comb begin
        n_pend  = r_pend;
        n_digit = r_digit;
        v_data  = '0;
        v_cnt   = '0;
        if (!r_mode) begin
            if (keeps_as_is(b)) begin
                v_data[0] = b;
                v_cnt     = JobCntW'(1);
            end else if (b == ChSpace) begin
                v_data[0] = ChPlus;
                v_cnt     = JobCntW'(1);
            end else begin
                v_data[0] = ChPercent;
                v_data[1] = hex_char(b[7:4]);
                v_data[2] = hex_char(b[3:0]);
                v_cnt     = JobCntW'(3);
            end
        end else begin
            case (r_pend)
                PendPct: begin
                    n_pend = PendNone;
                    if (is_hex(b)) begin
                        if (last) begin
                            v_data[0] = ChPercent;
                            v_data[1] = b;
                            v_cnt     = JobCntW'(2);
                        end else begin
                            n_pend  = PendDigit;
                            n_digit = b;
                        end
                    end else begin
                        v_data[0] = ChPercent;
                        v_cnt     = JobCntW'(1);
                        if (p_hold) begin
                            n_pend = PendPct;
                        end else begin
                            v_data[1] = p_byte;
                            v_cnt     = JobCntW'(2);
                        end
                    end
                end
                PendDigit: begin
                    n_pend = PendNone;
                    if (is_hex(b)) begin
                        v_data[0] = {hex_val(r_digit), hex_val(b)};
                        v_cnt     = JobCntW'(1);
                    end else begin
                        v_data[0] = ChPercent;
                        v_data[1] = r_digit;
                        v_cnt     = JobCntW'(2);
                        if (p_hold) begin
                            n_pend = PendPct;
                        end else begin
                            v_data[2] = p_byte;
                            v_cnt     = JobCntW'(3);
                        end
                    end
                end
                default: begin
                    n_pend = PendNone;
                    if (p_hold) begin
                        n_pend = PendPct;
                    end else begin
                        v_data[0] = p_byte;
                        v_cnt     = JobCntW'(1);
                    end
                end
            endcase
        end
        // nothing stays held past the end of a string
        if (last) begin
            n_pend = PendNone;
        end
    end

    assign o_push     = accept & (v_cnt != '0);
    assign o_job.data = v_data;
    assign o_job.cnt  = v_cnt;
    assign o_job.last = last;

endmodule

// File: rtl/ufpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufpc_queue
// Short first-in first-out queue of jobs between the classifying front
// and the emitting back.
// ----------------------------------------------------------------------------
module ufpc_queue import ufpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job           r_mem [QDepth];
    logic [QAw-1:0] r_wr_ptr;
    logic [QAw-1:0] r_rd_ptr;
    logic [QCw-1:0] r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QAw'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QAw'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCw'(1);
                2'b01:   r_count <= r_count - QCw'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == QCw'(QDepth));
    assign o_stat.empty = (r_count == '0);

endmodule

// File: rtl/ufpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufpc_back
// Takes jobs from the queue and sends their bytes out one per cycle while
// the output is not stalled, marking the final byte of a string.
// ----------------------------------------------------------------------------
module ufpc_back import ufpc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_job  i_head,
    input  logic  i_q_empty,
    output logic  o_pop,
    output logic  o_out_valid,
    output t_out  o_out,
    input  logic  i_out_stall
);

    logic               r_busy;
    t_job               r_job;
    logic [JobCntW-1:0] r_idx;
    logic               out_fire;
    logic               at_end;
    logic               free;

    assign out_fire = r_busy & ~i_out_stall;
    assign at_end   = (r_idx == (r_job.cnt - JobCntW'(1)));
    assign free     = ~r_busy | (out_fire & at_end);
    assign o_pop    = free & ~i_q_empty;

    // current job and byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_fire) begin
            if (at_end) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + JobCntW'(1);
            end
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
    end

    assign o_out_valid    = r_busy;
    assign o_out.out_byte = r_job.data[r_idx];
    assign o_out.out_last = r_job.last & at_end;

endmodule

// File: rtl/url_form_percent_codec_top.sv
`timescale 1ns / 1ps
// Path: an accepted byte's job is written into the job queue at the accepting edge,
// then popped into the back end's job register, which drives its output bytes.
// Throughput: one input byte per cycle while the output keeps up; the output moves
// one byte per cycle, so a run of three-byte escapes fills the four-entry job queue
// and the input then stalls whenever the queue is full.
// Reset: synchronous, active low; clears the mode, held escape state and queue.
// ----------------------------------------------------------------------------
// url_form_percent_codec_top
// Form-urlencoded percent encoder and decoder with a decoupled front
// (classify) and back (emit) joined by a short job queue.
// ----------------------------------------------------------------------------
module url_form_percent_codec_top import ufpc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out,
    input  logic i_out_stall,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    t_job    push_job;
    t_job    head_job;
    logic    push;
    logic    pop;
    t_q_stat q_stat;

    // classify
    ufpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_stat.full),
        .o_push      (push),
        .o_job       (push_job)
    );

    // job queue
    ufpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    // emit
    ufpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_q_empty   (q_stat.empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    // queue never overfills
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= QCw'(QDepth))
        else $error("job queue count above depth");

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("push into full job queue");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty job queue");

    // a job pushed into an empty idle path is popped by the back end and shows up at the output
    a_push_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && q_stat.empty && !o_out_valid) |-> ##2 o_out_valid)
        else $error("queued job not picked up by the back end");

endmodule
